// File: rtl/scp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and IEEE single-precision arithmetic for the sine/cosine pipeline.
// Used by scp_cell and sine_cosine_polynomial; depends on nothing else.
package scp_pkg;

   localparam int        NUM_CELLS = 18;
   localparam logic [31:0] QNAN    = 32'h7FC0_0000;

   typedef enum logic [3:0] {
      OP_QMUL  = 4'd0,
      OP_QRND  = 4'd1,
      OP_TRUNC = 4'd2,
      OP_TMUL  = 4'd3,
      OP_YSUB  = 4'd4,
      OP_FOLD  = 4'd5,
      OP_SQR   = 4'd6,
      OP_HMUL0 = 4'd7,
      OP_HADD  = 4'd8,
      OP_HMUL  = 4'd9,
      OP_FINAL = 4'd10
   } cell_op_type;

   typedef struct packed {
      logic        kind;
      logic        nan;
      logic        fold;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] y2;
      logic [31:0] acc;
   } stage_type;

   // Rounds a real to the nearest single-precision pattern (ties to even).
   // Only used at elaboration for the constants below; all of them are normal numbers.
   function automatic logic [31:0] to_fp(input real v);
      real         a;
      real         rem;
      int          e;
      longint      t;
      logic        s;
      logic [23:0] m;
      s = (v < 0.0);
      a = s ? -v : v;
      e = 0;
      for (int i = 0; i < 200; i++) begin
         if (a >= 2.0) begin
            a = a / 2.0;
            e++;
         end
      end
      for (int i = 0; i < 200; i++) begin
         if (a < 1.0) begin
            a = a * 2.0;
            e--;
         end
      end
      a = a * 8388608.0;
      t = longint'(a);
      if (real'(t) > a) t--;
      rem = a - real'(t);
      if (rem > 0.5 || (rem == 0.5 && t[0])) t++;
      if (t >= 64'sd16777216) begin
         t = t >>> 1;
         e++;
      end
      m = t[23:0];
      return {s, 8'(e + 127), m[22:0]};
   endfunction

   localparam logic [31:0] INV_TWO_PI = to_fp(0.159154943);
   localparam logic [31:0] TWO_PI     = to_fp(6.283185307);
   localparam logic [31:0] PI_FULL    = to_fp(3.141592654);
   localparam logic [31:0] PI_HALF    = to_fp(1.570796327);
   localparam logic [31:0] FP_HALF    = 32'h3F00_0000;

   // Horner coefficients, row 0 for sine and row 1 for cosine, highest order first.
   // Subtractions of the source are folded into negative coefficients.
   localparam logic [31:0] COEF [2][6] = '{
      '{to_fp(-2.3889859e-08), to_fp(2.7525562e-06), to_fp(-0.00019840874),
        to_fp(0.0083333310), to_fp(-0.16666667), 32'h3F80_0000},
      '{to_fp(-2.6051615e-07), to_fp(2.4760495e-05), to_fp(-0.0013888378),
        to_fp(0.041666638), to_fp(-0.5), 32'h3F80_0000}
   };

   localparam cell_op_type CELL_OP [NUM_CELLS] = '{
      OP_QMUL, OP_QRND, OP_TRUNC, OP_TMUL, OP_YSUB, OP_FOLD, OP_SQR, OP_HMUL0,
      OP_HADD, OP_HMUL, OP_HADD, OP_HMUL, OP_HADD, OP_HMUL, OP_HADD, OP_HMUL,
      OP_HADD, OP_FINAL
   };

   localparam int CELL_COEF [NUM_CELLS] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 2, 0, 3, 0, 4, 0, 5, 0
   };

   function automatic logic is_nan(input logic [31:0] a);
      return (&a[30:23]) && (|a[22:0]);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return (&a[30:23]) && !(|a[22:0]);
   endfunction

   // Single-precision multiply, round to nearest even, with subnormals.
   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        s;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [47:0] p;
      logic [47:0] pn;
      logic [49:0] t;
      logic [49:0] mask;
      logic        sticky;
      logic        rb;
      logic [32:0] res;
      int          pos;
      int          e;
      int          sh;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return QNAN;
      if ((is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0)) return QNAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'h0};
      if (a[30:0] == '0 || b[30:0] == '0) return {s, 31'h0};
      ma = {|a[30:23], a[22:0]};
      mb = {|b[30:23], b[22:0]};
      p  = ma * mb;
      pos = 0;
      for (int i = 0; i < 48; i++) begin
         if (p[i]) pos = i;
      end
      pn = p << (47 - pos);
      e = ((a[30:23] == '0) ? 1 : int'(a[30:23])) + ((b[30:23] == '0) ? 1 : int'(b[30:23]))
          - 126 - (47 - pos);
      sh = 0;
      if (e < 1) begin
         sh = 1 - e;
         e  = 1;
      end
      if (sh > 49) sh = 49;
      t      = {pn, 2'b00};
      mask   = (50'h1 << sh) - 50'h1;
      sticky = |(t & mask);
      t      = t >> sh;
      sticky = sticky | (|t[24:0]);
      rb     = t[25] & (sticky | t[26]);
      res    = ((33'(e) - 33'd1) << 23) + 33'(t[49:26]) + 33'(rb);
      if (res >= 33'h0_7F80_0000) return {s, 8'hFF, 23'h0};
      return {s, res[30:0]};
   endfunction

   // Single-precision add, round to nearest even, with subnormals.
   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] sml;
      logic [26:0] am;
      logic [26:0] bm;
      logic [26:0] bs;
      logic [26:0] mask;
      logic [27:0] sum;
      logic [26:0] m;
      logic        rb;
      logic [32:0] res;
      int          eb;
      int          es;
      int          d;
      int          pos;
      int          lz;
      int          e;
      if (is_nan(a) || is_nan(b)) return QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb = (big[30:23] == '0) ? 1 : int'(big[30:23]);
      es = (sml[30:23] == '0) ? 1 : int'(sml[30:23]);
      d  = eb - es;
      am = {|big[30:23], big[22:0], 3'b000};
      bm = {|sml[30:23], sml[22:0], 3'b000};
      if (d > 26) begin
         bs = {26'h0, |bm};
      end else begin
         mask = (27'h1 << d) - 27'h1;
         bs   = (bm >> d) | {26'h0, |(bm & mask)};
      end
      if (a[31] != b[31]) sum = {1'b0, am} - {1'b0, bs};
      else                sum = {1'b0, am} + {1'b0, bs};
      if (sum == '0) return {a[31] & b[31], 31'h0};
      e = eb;
      if (sum[27]) begin
         m = sum[27:1] | {26'h0, sum[0]};
         e = e + 1;
      end else begin
         pos = 0;
         for (int i = 0; i < 27; i++) begin
            if (sum[i]) pos = i;
         end
         lz = 26 - pos;
         if (lz > e - 1) lz = e - 1;
         m = sum[26:0] << lz;
         e = e - lz;
      end
      rb  = m[2] & (m[1] | m[0] | m[3]);
      res = ((33'(e) - 33'd1) << 23) + 33'(m[26:3]) + 33'(rb);
      if (res >= 33'h0_7F80_0000) return {big[31], 8'hFF, 23'h0};
      return {big[31], res[30:0]};
   endfunction

   // Truncation toward zero with saturation to the 32-bit integer range, back in single.
   function automatic logic [31:0] trunc_sat(input logic [31:0] v);
      logic [31:0] mask;
      if (v[30:23] < 8'd127) return 32'h0;
      if (v[30:23] >= 8'd158) return {v[31], 8'd158, 23'h0};
      if (v[30:23] >= 8'd150) return v;
      mask = (32'h1 << (8'd150 - v[30:23])) - 32'h1;
      return v & ~mask;
   endfunction

endpackage

// File: rtl/scp_cell.sv
`timescale 1ns / 1ps
// One cell of the evaluation chain: a single rounded float operation and its stage register.
// Depends on scp_pkg for the stage record, the op codes and the float arithmetic.
module scp_cell #(
   parameter scp_pkg::cell_op_type Op   = scp_pkg::OP_QMUL,
   parameter int                   Coef = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  scp_pkg::stage_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output scp_pkg::stage_type  out_data
);
   import scp_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   logic      fold_hi;
   logic      fold_lo;
   logic [31:0] final_val;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in   = in_data;
      fold_hi   = !in_data.y[31] && (in_data.y[30:0] > PI_HALF[30:0]);
      fold_lo   = in_data.y[31] && (in_data.y[30:0] > PI_HALF[30:0]);
      final_val = '0;
      unique case (Op)
         OP_QMUL: begin
            data_in.nan  = &in_data.x[30:23];
            data_in.fold = 1'b0;
            data_in.acc  = fp_mul(INV_TWO_PI, in_data.x);
         end
         OP_QRND: begin
            // Negative zero counts as non-negative here.
            data_in.acc = fp_add(in_data.acc,
               (in_data.x[31] && in_data.x[30:0] != '0) ? {1'b1, FP_HALF[30:0]} : FP_HALF);
         end
         OP_TRUNC: data_in.acc = trunc_sat(in_data.acc);
         OP_TMUL:  data_in.acc = fp_mul(TWO_PI, in_data.acc);
         OP_YSUB:  data_in.y   = fp_add(in_data.x, {~in_data.acc[31], in_data.acc[30:0]});
         OP_FOLD: begin
            if (fold_hi || fold_lo) begin
               data_in.fold = 1'b1;
               data_in.y    = fp_add({fold_lo, PI_FULL[30:0]},
                                     {~in_data.y[31], in_data.y[30:0]});
            end
         end
         OP_SQR:   data_in.y2  = fp_mul(in_data.y, in_data.y);
         OP_HMUL0: data_in.acc = fp_mul(COEF[in_data.kind][Coef], in_data.y2);
         OP_HADD:  data_in.acc = fp_add(in_data.acc, COEF[in_data.kind][Coef]);
         OP_HMUL:  data_in.acc = fp_mul(in_data.acc, in_data.y2);
         OP_FINAL: begin
            if (in_data.kind) begin
               final_val = in_data.fold ? {~in_data.acc[31], in_data.acc[30:0]} : in_data.acc;
            end else begin
               final_val = fp_mul(in_data.acc, in_data.y);
            end
            data_in.acc = (in_data.nan || is_nan(final_val)) ? QNAN : final_val;
         end
         default: data_in = in_data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/sine_cosine_polynomial.sv
`timescale 1ns / 1ps
// Single-precision sine/cosine by range reduction and a minimax polynomial.
// Top level: a chain of scp_cell stages; depends on scp_pkg.
//
// Usage:
//   The request channel carries one angle per beat: req_tdata is the IEEE single
//   angle in radians, req_tuser selects sine (0) or cosine (1).
//   The response channel returns one IEEE single value per request, in order.
//   A NaN or infinite angle, and any NaN result, comes back as 0x7FC00000.
//
// Timing:
//   The block is a chain of 18 cells, each doing one rounded float operation
//   and holding its result in its stage register. A request beat passes through
//   every cell register in order to the response beat; one beat is accepted
//   every cycle while rsp_tready does not stall the chain.
//
// Reset and stalls:
//   Synchronous reset empties every cell; no item is held afterward.
//   When rsp_tready is low the last cell holds its beat; earlier cells keep
//   moving into empty slots, so requests are still taken until the chain fills.
module sine_cosine_polynomial (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] value
);
   import scp_pkg::*;

   logic      valid_chain [NUM_CELLS + 1];
   logic      ready_chain [NUM_CELLS + 1];
   stage_type data_chain  [NUM_CELLS + 1];
   logic [NUM_CELLS-1:0] cell_valid;

   always_comb begin
      data_chain[0]      = '0;
      data_chain[0].kind = req_tuser;
      data_chain[0].x    = req_tdata;
   end

   assign valid_chain[0]         = req_tvalid;
   assign req_tready             = ready_chain[0];
   assign ready_chain[NUM_CELLS] = rsp_tready;
   assign rsp_tvalid             = valid_chain[NUM_CELLS];
   assign rsp_tdata              = data_chain[NUM_CELLS].acc;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      scp_cell #(
         .Op   (CELL_OP[i]),
         .Coef (CELL_COEF[i])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_data   (data_chain[i]),
         .out_valid (valid_chain[i + 1]),
         .out_ready (ready_chain[i + 1]),
         .out_data  (data_chain[i + 1])
      );
      assign cell_valid[i] = valid_chain[i + 1];
   end

`ifndef SYNTH
   // A refused request means every cell holds a beat.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&cell_valid))
      else $error("request refused while the chain has a free cell");

   // An accepted request always lands in the first cell.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cell_valid[0])
      else $error("accepted request missing from the first cell");

   // Any NaN leaving the block is the canonical quiet NaN.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (&rsp_tdata[30:23]) && (rsp_tdata[22:0] != '0))
         |-> (rsp_tdata == QNAN))
      else $error("non-canonical NaN on the response channel");

   // A stalled chain end lets nothing out of the last cell.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response beat changed while stalled");
`endif

endmodule
